// ----- hdl/isk_pkg.sv -----
// Package for the integer set store: field widths, operation and status codes,
// sequencer states and the default table size.
// Depends on nothing; used by every module of the block.
package isk_pkg;

    // Fixed widths of the request and result fields.
    localparam int FUNC_W       = 2;
    localparam int KEY_W        = 32;
    localparam int STATUS_W     = 2;
    localparam int COUNT_W      = 5;

    // Default number of slots in the key table.
    localparam int DEF_CAPACITY = 16;

    // Operation codes carried on the func field.
    typedef enum logic [FUNC_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_QUERY  = 2'd2,
        OP_CLEAR  = 2'd3
    } t_isk_op;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE   = 2'd0,
        ST_DUP    = 2'd1,
        ST_FULL   = 2'd2,
        ST_ABSENT = 2'd3
    } t_isk_status;

    // Sequencer states: clearing sweep, idle, table scan, and write back with result.
    typedef enum logic [1:0] {
        S_CLEAR  = 2'd0,
        S_IDLE   = 2'd1,
        S_SCAN   = 2'd2,
        S_UPDATE = 2'd3
    } t_isk_state;

endpackage

// ----- hdl/isk_mem.sv -----
// Slot memory of the integer set store: one write port, one read port,
// registered read data. Depends on isk_pkg for its default sizes.
module isk_mem #(
    parameter int DEPTH  = isk_pkg::DEF_CAPACITY,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int DATA_W = isk_pkg::KEY_W + 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port with registered data.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/integer_set_store.sv -----
// Integer set store: a bounded set of distinct 32-bit signed keys held in a
// slot memory, with a sequencer that scans, decides and writes back.
// Depends on isk_pkg and isk_mem.
//
// Usage:
// - Request channel (i_in_valid / o_in_stall) carries i_func and i_key_value.
//   A beat is taken when valid is high and stall is low.
// - Result channel (o_out_valid / i_out_stall) carries o_found, o_status and
//   o_entry_count, one result beat per request beat.
// - Insert, delete and query scan every slot through the single memory read
//   port, one slot a cycle, then write back. No new request is taken until
//   the current one has written back its result.
// - Clear sweeps the memory one slot a cycle and then gives its result.
// - After reset the same sweep runs with the request channel stalled; the
//   set is then empty.
// - The result sits in an output register. A new request is taken while it
//   waits; that request waits at write back until the old result is taken.
module integer_set_store #(
    parameter int CAPACITY = isk_pkg::DEF_CAPACITY
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [isk_pkg::FUNC_W-1:0]    i_func,
    input  logic signed [isk_pkg::KEY_W-1:0] i_key_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_found,
    output logic [isk_pkg::STATUS_W-1:0]  o_status,
    output logic [isk_pkg::COUNT_W-1:0]   o_entry_count
);

    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int KW   = isk_pkg::KEY_W;
    localparam int WW   = KW + 1;
    localparam int CNTW = isk_pkg::COUNT_W;
    localparam logic [CW-1:0] LAST_IDX = CW'(CAPACITY - 1);
    localparam logic [CW-1:0] END_IDX  = CW'(CAPACITY);

    isk_pkg::t_isk_state  r_state, n_state;
    logic [CW-1:0]        r_idx;
    logic                 r_rd_vld;
    logic [AW-1:0]        r_rd_idx;
    isk_pkg::t_isk_op     r_func;
    logic [KW-1:0]        r_key;
    logic                 r_op_clear;
    logic                 r_hit;
    logic [AW-1:0]        r_hit_idx;
    logic                 r_free;
    logic [AW-1:0]        r_free_idx;
    logic [CW-1:0]        r_count, n_count;
    logic                 r_out_valid;
    logic                 r_found, n_found;
    isk_pkg::t_isk_status r_status, n_status;
    logic [CNTW-1:0]      r_out_count;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [WW-1:0]        mem_wdata;
    logic [AW-1:0]        mem_raddr;
    logic [WW-1:0]        mem_rdata;
    logic                 in_stall;
    logic                 upd_go;
    logic                 in_take;
    logic                 slot_match;
    logic                 slot_empty;

    // Slot memory: valid bit above the key.
    isk_mem #(
        .DEPTH  (CAPACITY),
        .ADDR_W (AW),
        .DATA_W (WW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign in_take    = i_in_valid && !in_stall;
    assign slot_match = mem_rdata[KW] && (mem_rdata[KW-1:0] == r_key);
    assign slot_empty = !mem_rdata[KW];

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            isk_pkg::S_CLEAR: begin
                if (r_idx == LAST_IDX) begin
                    n_state = r_op_clear ? isk_pkg::S_UPDATE : isk_pkg::S_IDLE;
                end
            end
            isk_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (isk_pkg::t_isk_op'(i_func) == isk_pkg::OP_CLEAR) ?
                              isk_pkg::S_CLEAR : isk_pkg::S_SCAN;
                end
            end
            isk_pkg::S_SCAN: begin
                if (r_idx == END_IDX) begin
                    n_state = isk_pkg::S_UPDATE;
                end
            end
            isk_pkg::S_UPDATE: begin
                if (upd_go) begin
                    n_state = isk_pkg::S_IDLE;
                end
            end
            default: n_state = isk_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs: memory port control, request stall, write back.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_idx[AW-1:0];
        mem_wdata = '0;
        mem_raddr = r_idx[AW-1:0];
        in_stall  = 1'b1;
        upd_go    = 1'b0;
        case (r_state)
            isk_pkg::S_CLEAR: begin
                mem_we = 1'b1;
            end
            isk_pkg::S_IDLE: begin
                in_stall = 1'b0;
            end
            isk_pkg::S_SCAN: begin
                mem_we = 1'b0;
            end
            isk_pkg::S_UPDATE: begin
                upd_go = !r_out_valid || !i_out_stall;
                if (upd_go && r_func == isk_pkg::OP_INSERT && !r_hit && r_free) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_free_idx;
                    mem_wdata = {1'b1, r_key};
                end else if (upd_go && r_func == isk_pkg::OP_DELETE && r_hit) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_hit_idx;
                    mem_wdata = {1'b0, r_key};
                end
            end
            default: in_stall = 1'b1;
        endcase
    end

    // Result of the operation from the scan outcome.
    always_comb begin
        n_found  = r_hit;
        n_status = isk_pkg::ST_DONE;
        n_count  = r_count;
        case (r_func)
            isk_pkg::OP_INSERT: begin
                if (r_hit) begin
                    n_status = isk_pkg::ST_DUP;
                end else if (!r_free) begin
                    n_status = isk_pkg::ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            isk_pkg::OP_DELETE: begin
                if (r_hit) begin
                    n_count = r_count - 1'b1;
                end else begin
                    n_status = isk_pkg::ST_ABSENT;
                end
            end
            isk_pkg::OP_QUERY: begin
                n_status = r_hit ? isk_pkg::ST_DONE : isk_pkg::ST_ABSENT;
            end
            isk_pkg::OP_CLEAR: begin
                n_found = 1'b0;
                n_count = '0;
            end
            default: n_status = isk_pkg::ST_DONE;
        endcase
    end

    // Sequencer control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= isk_pkg::S_CLEAR;
            r_idx      <= '0;
            r_rd_vld   <= 1'b0;
            r_op_clear <= 1'b0;
            r_count    <= '0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == isk_pkg::S_SCAN) && (r_idx != END_IDX);
            case (r_state)
                isk_pkg::S_CLEAR: begin
                    r_idx <= (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
                end
                isk_pkg::S_IDLE: begin
                    r_idx <= '0;
                    if (in_take) begin
                        r_op_clear <= (isk_pkg::t_isk_op'(i_func) == isk_pkg::OP_CLEAR);
                    end
                end
                isk_pkg::S_SCAN: begin
                    if (r_idx != END_IDX) begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                isk_pkg::S_UPDATE: begin
                    if (upd_go) begin
                        r_count <= n_count;
                    end
                end
                default: r_idx <= '0;
            endcase
        end
    end

    // Request capture and scan tracking: first matching slot, lowest free slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit  <= 1'b0;
            r_free <= 1'b0;
        end else if (in_take) begin
            r_hit  <= 1'b0;
            r_free <= 1'b0;
        end else if (r_rd_vld) begin
            if (slot_match && !r_hit) begin
                r_hit <= 1'b1;
            end
            if (slot_empty && !r_free) begin
                r_free <= 1'b1;
            end
        end
    end

    // Payload of the scan: request fields and slot indexes.
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_idx[AW-1:0];
        if (in_take) begin
            r_func <= isk_pkg::t_isk_op'(i_func);
            r_key  <= i_key_value;
        end
        if (r_rd_vld && slot_match && !r_hit) begin
            r_hit_idx <= r_rd_idx;
        end
        if (r_rd_vld && slot_empty && !r_free) begin
            r_free_idx <= r_rd_idx;
        end
    end

    // Output register: a result beat is loaded at write back and held until taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (upd_go) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd_go) begin
            r_found     <= n_found;
            r_status    <= n_status;
            r_out_count <= CNTW'(n_count);
        end
    end

    assign o_in_stall    = in_stall;
    assign o_out_valid   = r_out_valid;
    assign o_found       = r_found;
    assign o_status      = r_status;
    assign o_entry_count = r_out_count;

    // The memory is written only by the clearing sweep or at write back.
    a_we_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == isk_pkg::S_CLEAR || r_state == isk_pkg::S_UPDATE))
        else $error("slot memory written outside sweep or write back");

    // The count never exceeds the table size.
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= END_IDX)
        else $error("entry count above capacity");

    // An insert that fills a slot raises the count by one.
    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && mem_wdata[KW]) |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not raise the count");

    // Write back always leaves a result beat waiting.
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd_go |=> r_out_valid)
        else $error("write back without a result beat");

endmodule
